FILE: hw/rtl/monochrome_draw_engine_top_assert.svh
// assertion macros for the drawing engine
`ifndef MONOCHROME_DRAW_ENGINE_TOP_ASSERT_SVH
`define MONOCHROME_DRAW_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MDE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("mde check failed");
`define MDE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error("mde check failed");
`else
`define MDE_ASSERT(label, clk, rst_n, prop)
`define MDE_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

FILE: hw/rtl/mde_pkg.sv
`timescale 1ns / 1ps
package mde_pkg;
  localparam int unsigned ScreenWidth  = 133;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CalcW  = 16;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_PIXEL  = 3'd1,
    ACT_LINE   = 3'd2,
    ACT_RECT   = 3'd3,
    ACT_CIRCLE = 3'd4,
    ACT_READ   = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SHAPE, ST_RMW_RD, ST_RMW_WR, ST_READ, ST_READ_WAIT, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    SH_POINT, SH_LINE, SH_RECT_H, SH_RECT_V, SH_CIRCLE, SH_CIRCLE_TAIL
  } shape_e;
endpackage

FILE: hw/rtl/mde_if.sv
`timescale 1ns / 1ps
interface mde_cmd_if;
  import mde_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               action;
  logic signed [CoordW-1:0] x_a;
  logic signed [CoordW-1:0] y_a;
  logic signed [CoordW-1:0] x_b;
  logic signed [CoordW-1:0] y_b;
  logic [10:0]              radius;
  logic                     pen_color;
  logic [10:0]              read_address;
  modport source (output valid, action, x_a, y_a, x_b, y_b, radius, pen_color,
                  read_address, input ready);
  modport sink (input valid, action, x_a, y_a, x_b, y_b, radius, pen_color,
                read_address, output ready);
endinterface

interface mde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

FILE: hw/rtl/mde_store.sv
`timescale 1ns / 1ps
module mde_store
  import mde_pkg::*;
#(
  parameter int unsigned Depth = 1064,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hw/rtl/monochrome_draw_engine_top.sv
`timescale 1ns / 1ps
// channel | dir | beat
// cmd_i   | in  | action, x_a, y_a, x_b, y_b, radius, pen_color, read_address
// rsp_o   | out | read_data
// per item: the accept, the work below, then the result beat is posted from the done state
// clear: one store byte per cycle over all width*pages bytes, also run once after reset
// a plotted pixel has address, read and write back steps; an off-screen point only address
// line: up to max(dx,dy)+1 points; rectangle: 2*(w+h+2) points; circle: 8 points per step
// read: address, then wait; cmd ready while idle, a done beat waits in the output register
// and the next item runs behind it, holding in its last state until that beat leaves
`include "monochrome_draw_engine_top_assert.svh"
module monochrome_draw_engine_top
  import mde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeight
) (
  input logic    clk_i,
  input logic    rst_ni,
  mde_cmd_if.sink   cmd_i,
  mde_rsp_if.source rsp_o
);
  localparam int unsigned Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned Depth = SCREEN_WIDTH * Pages;
  localparam int unsigned AddrW = $clog2(Depth + 1);

  state_e state_q, state_d;
  shape_e shape_q, shape_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic signed [CalcW-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [CalcW-1:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d, i_q, i_d;
  logic signed [CalcW-1:0] ca_q, ca_d, cb_q, cb_d;
  logic signed [CalcW+2:0] cd_q, cd_d;
  logic [3:0] sub_q, sub_d;
  logic pen_q, pen_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [7:0] rdat_q, rdat_d;
  logic rvalid_q, rvalid_d;
  logic [7:0] rsp_data_q, rsp_data_d;
  logic [7:0] mask_q, mask_d;
  logic [AddrW-1:0] paddr_q, paddr_d;
  logic cmd_seen_q;

  logic we;
  logic [AddrW-1:0] waddr, mraddr;
  logic [7:0] wdata, mrdata;

  mde_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(mraddr), .rdata_o(mrdata)
  );

  // current point to plot
  logic signed [CalcW-1:0] px, py;
  logic pt_ok, pt_last;
  always_comb begin
    px = x0_q;
    py = y0_q;
    pt_last = 1'b1;
    unique case (shape_q)
      SH_POINT: begin px = x1_q; py = y1_q; end
      SH_LINE:  begin px = sub_q[0] ? x1_q : x0_q; py = sub_q[0] ? y1_q : y0_q; end
      SH_RECT_H: begin px = i_q; py = sub_q[0] ? y1_q : y0_q; end
      SH_RECT_V: begin px = sub_q[0] ? x1_q : x0_q; py = i_q; end
      SH_CIRCLE, SH_CIRCLE_TAIL: begin
        px = sub_q[2] ? (sub_q[1] ? x0_q - cb_q : x0_q + cb_q)
                      : (sub_q[1] ? x0_q - ca_q : x0_q + ca_q);
        py = sub_q[2] ? (sub_q[0] ? y0_q - ca_q : y0_q + ca_q)
                      : (sub_q[0] ? y0_q - cb_q : y0_q + cb_q);
      end
      default: ;
    endcase
    pt_ok = (px >= 0) && (px < CalcW'(SCREEN_WIDTH)) && (py >= 0)
            && (py < CalcW'(SCREEN_HEIGHT));
  end

  logic [AddrW-1:0] pt_addr;
  logic [7:0] pt_mask;
  always_comb begin
    pt_addr = AddrW'(32'(py[CalcW-1:3]) * SCREEN_WIDTH + 32'(px));
    pt_mask = 8'(8'd1 << py[2:0]);
  end

  logic accept, rsp_fire;
  assign accept   = cmd_i.valid && cmd_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rvalid_q;
  assign rsp_o.read_data = rsp_data_q;

  // advance shape after a point; returns via next-state regs
  logic shape_end;
  logic signed [CalcW-1:0] e2;
  assign e2 = err_q <<< 1;

  always_comb begin
    state_d = state_q; shape_d = shape_q; clr_d = clr_q;
    x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    dx_d = dx_q; dy_d = dy_q; err_d = err_q; i_d = i_q;
    ca_d = ca_q; cb_d = cb_q; cd_d = cd_q; sub_d = sub_q;
    pen_d = pen_q; raddr_d = raddr_q; rdat_d = rdat_q; rvalid_d = rvalid_q;
    rsp_data_d = rsp_data_q;
    mask_d = mask_q; paddr_d = paddr_q;
    shape_end = 1'b0;
    if (rsp_fire) rvalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        pen_d = cmd_i.pen_color;
        rdat_d = '0;
        x0_d = CalcW'(cmd_i.x_a); y0_d = CalcW'(cmd_i.y_a);
        x1_d = CalcW'(cmd_i.x_b); y1_d = CalcW'(cmd_i.y_b);
        sub_d = '0;
        case (cmd_i.action)
          ACT_CLEAR: begin clr_d = '0; state_d = ST_CLEAR; end
          ACT_PIXEL: begin
            shape_d = SH_POINT; x1_d = CalcW'(cmd_i.x_a); y1_d = CalcW'(cmd_i.y_a);
            state_d = ST_SHAPE;
          end
          ACT_LINE: begin
            shape_d = SH_LINE; sub_d = 4'd1; state_d = ST_SHAPE;
            dx_d = (cmd_i.x_b > cmd_i.x_a) ? CalcW'(cmd_i.x_b) - CalcW'(cmd_i.x_a)
                                            : CalcW'(cmd_i.x_a) - CalcW'(cmd_i.x_b);
            dy_d = (cmd_i.y_b > cmd_i.y_a) ? CalcW'(cmd_i.y_b) - CalcW'(cmd_i.y_a)
                                            : CalcW'(cmd_i.y_a) - CalcW'(cmd_i.y_b);
            err_d = dx_d - dy_d;
          end
          ACT_RECT: begin
            shape_d = SH_RECT_H; state_d = ST_SHAPE;
            if (cmd_i.x_b < cmd_i.x_a) begin
              x0_d = CalcW'(cmd_i.x_b); x1_d = CalcW'(cmd_i.x_a);
            end
            if (cmd_i.y_b < cmd_i.y_a) begin
              y0_d = CalcW'(cmd_i.y_b); y1_d = CalcW'(cmd_i.y_a);
            end
            i_d = x0_d;
          end
          ACT_CIRCLE: begin
            shape_d = SH_CIRCLE; state_d = ST_SHAPE;
            ca_d = '0; cb_d = CalcW'(cmd_i.radius);
            cd_d = (CalcW+3)'(3) - ((CalcW+3)'(cmd_i.radius) <<< 1);
            if (cmd_i.radius == '0) shape_d = SH_CIRCLE_TAIL;
          end
          ACT_READ: begin
            raddr_d = AddrW'(cmd_i.read_address);
            state_d = (32'(cmd_i.read_address) < Depth) ? ST_READ : ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Depth - 1) state_d = ST_DONE;
      end
      ST_SHAPE: begin
        if (pt_ok) begin
          paddr_d = pt_addr; mask_d = pt_mask; state_d = ST_RMW_RD;
        end else begin
          shape_end = 1'b1;
        end
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: begin state_d = ST_SHAPE; shape_end = 1'b1; end
      ST_READ: state_d = ST_READ_WAIT;
      ST_READ_WAIT: begin rdat_d = mrdata; state_d = ST_DONE; end
      ST_DONE: begin
        if (!rvalid_q || rsp_fire) begin
          rvalid_d = 1'b1; rsp_data_d = rdat_q; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // step the shape after a plotted or skipped point
    if (shape_end) begin
      state_d = ST_SHAPE;
      unique case (shape_q)
        SH_POINT: state_d = ST_DONE;
        SH_LINE: begin
          if (sub_q[0]) begin
            sub_d = '0;
            if (x0_q == x1_q && y0_q == y1_q) state_d = ST_DONE;
          end else begin
            if (e2 > -dy_q) begin
              err_d = err_q - dy_q;
              x0_d = (x0_q < x1_q) ? x0_q + 1'b1 : x0_q - 1'b1;
            end
            if (e2 < dx_q) begin
              err_d = err_d + dx_q;
              y0_d = (y0_q < y1_q) ? y0_q + 1'b1 : y0_q - 1'b1;
            end
            if (x0_d == x1_q && y0_d == y1_q) state_d = ST_DONE;
          end
        end
        SH_RECT_H: begin
          sub_d = {3'b0, ~sub_q[0]};
          if (sub_q[0]) begin
            if (i_q == x1_q) begin shape_d = SH_RECT_V; i_d = y0_q; end
            else i_d = i_q + 1'b1;
          end
        end
        SH_RECT_V: begin
          sub_d = {3'b0, ~sub_q[0]};
          if (sub_q[0]) begin
            if (i_q == y1_q) state_d = ST_DONE;
            else i_d = i_q + 1'b1;
          end
        end
        SH_CIRCLE: begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 4'd7) begin
            sub_d = '0;
            if (cd_q < 0) begin
              cd_d = cd_q + ((CalcW+3)'(ca_q) <<< 2) + (CalcW+3)'(6);
              cb_d = cb_q;
            end else begin
              cd_d = cd_q + ((CalcW+3)'(ca_q - cb_q) <<< 2) + (CalcW+3)'(10);
              cb_d = cb_q - 1'b1;
            end
            ca_d = ca_q + 1'b1;
            if (!(ca_d < cb_d)) begin
              if (ca_d == cb_d) shape_d = SH_CIRCLE_TAIL;
              else state_d = ST_DONE;
            end
          end
        end
        SH_CIRCLE_TAIL: begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 4'd3) state_d = ST_DONE;
        end
        default: state_d = ST_DONE;
      endcase
    end
  end

  always_comb begin
    we = 1'b0; waddr = paddr_q; wdata = '0; mraddr = paddr_q;
    unique case (state_q)
      ST_CLEAR: begin we = 1'b1; waddr = clr_q; wdata = '0; end
      ST_SHAPE: mraddr = pt_addr;
      ST_RMW_WR: begin
        we = 1'b1;
        wdata = pen_q ? (mrdata | mask_q) : (mrdata & ~mask_q);
      end
      ST_READ: mraddr = raddr_q;
      default: ;
    endcase
  end

  // reset enters the clear sweep so the store starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; rvalid_q <= 1'b0; shape_q <= SH_POINT;
      sub_q <= '0;
    end else begin
      state_q <= (state_q == ST_CLEAR && state_d == ST_DONE && !cmd_seen_q)
                 ? ST_IDLE : state_d;
      clr_q <= clr_d; rvalid_q <= rvalid_d; shape_q <= shape_d; sub_q <= sub_d;
    end
  end

  // flags the reset sweep so it gives no result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cmd_seen_q <= 1'b0;
    else if (accept) cmd_seen_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    dx_q <= dx_d; dy_q <= dy_d; err_q <= err_d; i_q <= i_d;
    ca_q <= ca_d; cb_q <= cb_d; cd_q <= cd_d;
    pen_q <= pen_d; raddr_q <= raddr_d; rdat_q <= rdat_d;
    rsp_data_q <= rsp_data_d;
    mask_q <= mask_d; paddr_q <= paddr_d;
  end

  `MDE_ASSERT(a_no_accept_busy, clk_i, rst_ni, accept |-> state_q == ST_IDLE)
  `MDE_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_o.read_data))
  `MDE_ASSERT_NEXT(a_rmw_write, clk_i, rst_ni, state_q == ST_RMW_RD, state_q == ST_RMW_WR)
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mde_pkg::*;

  localparam int          PageCount  = (ScreenHeight + 7) / 8;
  localparam int          StoreBytes = ScreenWidth * PageCount;
  localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam int          SettleCycles = 50;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic [10:0]        radius;
    logic               pen_color;
    logic [10:0]        read_address;
  } draw_cmd_t;

  logic clk_i;
  logic rst_ni;

  mde_cmd_if cmd_if ();
  mde_rsp_if rsp_if ();

  monochrome_draw_engine_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .rsp_o  (rsp_if.source)
  );

  logic [7:0] shadow_fb [StoreBytes];
  logic [7:0] read_expect_q [$];
  int         mismatches;
  int         beats_sent;
  int         beats_checked;
  int         sender_idle_pct;
  int         rsp_stall_pct;
  int         hold_off_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // framebuffer shadow
  function automatic void fb_plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= ScreenWidth || y < 0 || y >= ScreenHeight) return;
    idx = (y / 8) * ScreenWidth + x;
    if (on) shadow_fb[idx][y % 8] = 1'b1;
    else shadow_fb[idx][y % 8] = 1'b0;
  endfunction

  function automatic void fb_line(int x0, int y0, int x1, int y1, bit on);
    int dx, dy, sx, sy, err, e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    fb_plot(x1, y1, on);
    while (x0 != x1 || y0 != y1) begin
      e2 = err * 2;
      fb_plot(x0, y0, on);
      if (e2 > -dy) begin
        err -= dy;
        x0 += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y0 += sy;
      end
    end
  endfunction

  function automatic void fb_rect(int x0, int y0, int x1, int y1, bit on);
    int t;
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (y1 < y0) begin
      t = y0; y0 = y1; y1 = t;
    end
    for (int i = x0; i <= x1; i++) begin
      fb_plot(i, y0, on);
      fb_plot(i, y1, on);
    end
    for (int i = y0; i <= y1; i++) begin
      fb_plot(x0, i, on);
      fb_plot(x1, i, on);
    end
  endfunction

  function automatic void fb_quad(int cx, int cy, int a, int b, bit on);
    fb_plot(cx + a, cy + b, on);
    fb_plot(cx + a, cy - b, on);
    fb_plot(cx - a, cy + b, on);
    fb_plot(cx - a, cy - b, on);
  endfunction

  function automatic void fb_circle(int cx, int cy, int r, bit on);
    int a, b, d;
    a = 0;
    b = r;
    d = 3 - 2 * r;
    while (a < b) begin
      fb_quad(cx, cy, a, b, on);
      fb_quad(cx, cy, b, a, on);
      if (d < 0) d += 4 * a + 6;
      else begin
        d += 4 * (a - b) + 10;
        b--;
      end
      a++;
    end
    if (a == b) fb_quad(cx, cy, a, b, on);
  endfunction

  function automatic logic [7:0] apply_draw_cmd(draw_cmd_t c);
    logic [7:0] data;
    data = 8'h00;
    case (c.action)
      ACT_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      ACT_PIXEL: fb_plot(c.x_a, c.y_a, c.pen_color);
      ACT_LINE: fb_line(c.x_a, c.y_a, c.x_b, c.y_b, c.pen_color);
      ACT_RECT: fb_rect(c.x_a, c.y_a, c.x_b, c.y_b, c.pen_color);
      ACT_CIRCLE: fb_circle(c.x_a, c.y_a, int'(c.radius), c.pen_color);
      ACT_READ: if (c.read_address < StoreBytes) data = shadow_fb[c.read_address];
      default: data = 8'h00;
    endcase
    return data;
  endfunction

  // response side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      rsp_if.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (read_expect_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual read_data %h",
                 $time, rsp_if.read_data);
        mismatches++;
      end else begin
        if (rsp_if.read_data !== read_expect_q[0]) begin
          $display("%0t: read_data mismatch, expected %h, actual %h",
                   $time, read_expect_q[0], rsp_if.read_data);
          mismatches++;
        end
        void'(read_expect_q.pop_front());
        beats_checked++;
      end
    end
  end

  // command side, called at a rising edge
  task automatic send_cmd(draw_cmd_t c);
    cmd_if.valid        <= 1'b1;
    cmd_if.action       <= c.action;
    cmd_if.x_a          <= c.x_a;
    cmd_if.y_a          <= c.y_a;
    cmd_if.x_b          <= c.x_b;
    cmd_if.y_b          <= c.y_b;
    cmd_if.radius       <= c.radius;
    cmd_if.pen_color    <= c.pen_color;
    cmd_if.read_address <= c.read_address;
    do @(posedge clk_i); while (!cmd_if.ready);
    read_expect_q.push_back(apply_draw_cmd(c));
    beats_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  task automatic go_quiet();
    cmd_if.valid <= 1'b0;
    wait (read_expect_q.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic draw_cmd_t mk_cmd(logic [2:0] act, int xa, int ya, int xb, int yb,
                                       int r, bit pen, int addr);
    draw_cmd_t c;
    c.action       = act;
    c.x_a          = 12'(xa);
    c.y_a          = 12'(ya);
    c.x_b          = 12'(xb);
    c.y_b          = 12'(yb);
    c.radius       = 11'(r);
    c.pen_color    = pen;
    c.read_address = 11'(addr);
    return c;
  endfunction

  function automatic int rand_coord(int span);
    case ($urandom_range(29))
      0: return int'($signed(12'($urandom)));
      1, 2: return $urandom_range(1) ? -1 - $urandom_range(3) : span + $urandom_range(3);
      default: return $urandom_range(span - 1);
    endcase
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int        sel;
    int        addr;
    sel = $urandom_range(99);
    addr = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(StoreBytes - 1);
    c = mk_cmd(ACT_READ, rand_coord(ScreenWidth), rand_coord(ScreenHeight),
               rand_coord(ScreenWidth), rand_coord(ScreenHeight),
               ($urandom_range(39) == 0) ? $urandom_range(2047) : $urandom_range(40),
               ($urandom_range(3) != 0), addr);
    if (sel < 1) c.action = ACT_CLEAR;
    else if (sel < 16) c.action = ACT_PIXEL;
    else if (sel < 28) c.action = ACT_LINE;
    else if (sel < 36) c.action = ACT_RECT;
    else if (sel < 44) c.action = ACT_CIRCLE;
    else if (sel < 46) c.action = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    return c;
  endfunction

  task automatic test_directed();
    sender_idle_pct = 0;
    rsp_stall_pct = 0;
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_PIXEL, ScreenWidth - 1, ScreenHeight - 1, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_PIXEL, -1, 5, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_PIXEL, ScreenWidth, ScreenHeight, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_PIXEL, -2048, 2047, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, StoreBytes - 1));
    send_cmd(mk_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(ACT_LINE, 10, 10, 10, 10, 0, 1, 0));
    send_cmd(mk_cmd(ACT_LINE, -2048, -2048, 2047, 2047, 0, 1, 0));
    send_cmd(mk_cmd(ACT_LINE, 130, 2, 3, 60, 0, 1, 0));
    send_cmd(mk_cmd(ACT_RECT, 100, 50, 20, 5, 0, 1, 0));
    send_cmd(mk_cmd(ACT_RECT, 40, 30, 40, 30, 0, 1, 0));
    send_cmd(mk_cmd(ACT_RECT, 5, 20, 60, 20, 0, 1, 0));
    send_cmd(mk_cmd(ACT_CIRCLE, 66, 32, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_CIRCLE, 66, 32, 30, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_CIRCLE, 0, 0, 2047, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_CIRCLE, 66, 32, 30, 0, 0, 0, 0));
    send_cmd(mk_cmd(ACT_SPARE_LO, 1, 1, 0, 0, 0, 1, 1));
    send_cmd(mk_cmd(ACT_SPARE_HI, 1, 1, 0, 0, 0, 1, 1));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, StoreBytes));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 2047));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, ScreenWidth + 66));
    send_cmd(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 1, 0));
    send_cmd(mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, ScreenWidth + 66));
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    sender_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) send_cmd(rand_cmd());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_cycles <= 400;
    repeat (15) send_cmd(rand_cmd());
  endtask

  task automatic test_drain_pause();
    sender_idle_pct = 20;
    rsp_stall_pct = 30;
    repeat (10) send_cmd(rand_cmd());
    go_quiet();
    repeat (10) send_cmd(rand_cmd());
  endtask

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    sender_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_cycles = 0;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_CLEAR;
    cmd_if.x_a = '0;
    cmd_if.y_a = '0;
    cmd_if.x_b = '0;
    cmd_if.y_b = '0;
    cmd_if.radius = '0;
    cmd_if.pen_color = 1'b0;
    cmd_if.read_address = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 170);
    test_random_phase(79, 0, 170);
    test_random_phase(0, 79, 170);
    test_random_phase(28, 28, 170);
    test_backpressure();
    test_drain_pause();
    go_quiet();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d commands (clear, pixel, line, rect, circle, read, unused codes)",
             beats_sent);
    $display("checked %0d read beats under idle, stall and hold-off mixes", beats_checked);
    if (mismatches == 0 && read_expect_q.size() == 0) begin
      $display("monochrome_draw_engine_top regression: pass");
    end else begin
      $display("monochrome_draw_engine_top regression: fail");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d beats outstanding", read_expect_q.size());
    $display("monochrome_draw_engine_top regression: fail");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mde_pkg.sv
hw/rtl/mde_if.sv
hw/rtl/mde_store.sv
hw/rtl/monochrome_draw_engine_top.sv
tb/tb_top.sv
